// File: sv/alfrng_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants, microcode table and helpers of the lagged Fibonacci generator.
package alfrng_pkg;

    localparam int DEF_TABLE_DEPTH = 55;
    localparam int DEF_INDEX_GAP   = 31;
    localparam int DEF_WORD_BITS   = 30;

    localparam int SEED_BITS  = 30;
    localparam int RANGE_BITS = 16;
    localparam int VALUE_BITS = 31;
    localparam int OP_BITS    = 2;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic [SEED_BITS-1:0] SEED_RESET = SEED_BITS'(1);

    // Register number as seen in the word address bit of paddr.
    localparam logic REG_SEED = 1'b0;

    localparam int                   MAX_TRIES = 4096;
    localparam int                   TRY_BITS  = $clog2(MAX_TRIES);
    localparam logic [TRY_BITS-1:0]  TRY_LAST  = TRY_BITS'(MAX_TRIES - 1);

    // Reseed builds entries up to and including this one.
    localparam int                   FILL_BITS = 4;
    localparam logic [FILL_BITS-1:0] FILL_LAST = FILL_BITS'(9);

    localparam logic [OP_BITS-1:0] OP_RESEED = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RAW    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_RANGED = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE   = 2'd3;

    typedef logic [3:0] step_t;

    localparam step_t S_FETCH   = 4'd0;
    localparam step_t S_RS_INIT = 4'd1;
    localparam step_t S_RS_FILL = 4'd2;
    localparam step_t S_RS_DONE = 4'd3;
    localparam step_t S_RAW_RD  = 4'd4;
    localparam step_t S_RAW_WR  = 4'd5;
    localparam step_t S_RNG_CHK = 4'd6;
    localparam step_t S_RNG_RD  = 4'd7;
    localparam step_t S_RNG_WR  = 4'd8;
    localparam step_t S_RNG_END = 4'd9;
    localparam step_t S_NOP     = 4'd10;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_IF,
        JMP_DISPATCH
    } jmp_t;

    typedef enum logic [1:0] {
        CND_FILL_MORE,
        CND_SPAN_SMALL,
        CND_MISS_MORE
    } cond_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_RS_INIT,
        ACT_RS_FILL,
        ACT_RS_DONE,
        ACT_READ,
        ACT_DRAW,
        ACT_DRAW_RNG
    } act_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_SUM,
        SEL_RANGED
    } sel_t;

    typedef struct packed {
        logic  fetch;
        logic  emit;
        sel_t  sel;
        act_t  act;
        jmp_t  jmp;
        cond_t cond;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic fill_more;
        logic span_small;
        logic miss_more;
    } dp_stat_t;

    function automatic ucw_t ucw(logic fetch, logic emit, sel_t sel, act_t act,
                                 jmp_t jmp, cond_t cond, step_t target);
        ucw_t w;
        w.fetch  = fetch;
        w.emit   = emit;
        w.sel    = sel;
        w.act    = act;
        w.jmp    = jmp;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The control program.
    function automatic ucw_t ucode_rom(step_t s);
        ucw_t w;
        unique case (s)
            S_FETCH:   w = ucw(1'b1, 1'b0, SEL_ZERO, ACT_LATCH, JMP_DISPATCH,
                               CND_FILL_MORE, S_FETCH);
            S_RS_INIT: w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_RS_INIT, JMP_NEXT,
                               CND_FILL_MORE, S_FETCH);
            S_RS_FILL: w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_RS_FILL, JMP_IF,
                               CND_FILL_MORE, S_RS_FILL);
            S_RS_DONE: w = ucw(1'b0, 1'b1, SEL_ZERO, ACT_RS_DONE, JMP_GOTO,
                               CND_FILL_MORE, S_FETCH);
            S_RAW_RD:  w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_READ, JMP_NEXT,
                               CND_FILL_MORE, S_FETCH);
            S_RAW_WR:  w = ucw(1'b0, 1'b1, SEL_SUM, ACT_DRAW, JMP_GOTO,
                               CND_FILL_MORE, S_FETCH);
            S_RNG_CHK: w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_NONE, JMP_IF,
                               CND_SPAN_SMALL, S_RNG_END);
            S_RNG_RD:  w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_READ, JMP_NEXT,
                               CND_FILL_MORE, S_FETCH);
            S_RNG_WR:  w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_DRAW_RNG, JMP_IF,
                               CND_MISS_MORE, S_RNG_RD);
            S_RNG_END: w = ucw(1'b0, 1'b1, SEL_RANGED, ACT_NONE, JMP_GOTO,
                               CND_FILL_MORE, S_FETCH);
            S_NOP:     w = ucw(1'b0, 1'b1, SEL_ZERO, ACT_NONE, JMP_GOTO,
                               CND_FILL_MORE, S_FETCH);
            default:   w = ucw(1'b0, 1'b0, SEL_ZERO, ACT_NONE, JMP_GOTO,
                               CND_FILL_MORE, S_FETCH);
        endcase
        return w;
    endfunction

    // Sets every bit below the highest set bit: the mask of the next power of two.
    function automatic logic [RANGE_BITS-1:0] smear16(logic [RANGE_BITS-1:0] d);
        logic [RANGE_BITS-1:0] m;
        m = d;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

endpackage

// File: sv/alfrng_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control table lookup and branch logic.
module alfrng_seq
    import alfrng_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [OP_BITS-1:0] op,
    input  logic               out_blocked,
    input  dp_stat_t           stat,
    output ucw_t               cw,
    output logic               go,
    output logic               in_stall
);

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    assign cw       = ucode_rom(step_reg);
    assign in_stall = !cw.fetch;

    // A step that emits waits while the output register still holds an untaken beat.
    assign go = cw.fetch ? in_valid : !(cw.emit && out_blocked);

    always_comb
    begin
        unique case (cw.cond)
            CND_FILL_MORE:  cond_true = stat.fill_more;
            CND_SPAN_SMALL: cond_true = stat.span_small;
            CND_MISS_MORE:  cond_true = stat.miss_more;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            unique case (cw.jmp)
                JMP_NEXT: step_next = step_reg + 4'd1;
                JMP_GOTO: step_next = cw.target;
                JMP_IF:   step_next = cond_true ? cw.target : step_reg + 4'd1;
                JMP_DISPATCH:
                begin
                    unique case (op)
                        OP_RESEED: step_next = S_RS_INIT;
                        OP_RAW:    step_next = S_RAW_RD;
                        OP_RANGED: step_next = S_RNG_CHK;
                        OP_NONE:   step_next = S_NOP;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: sv/alfrng_dp.sv
`timescale 1ns / 1ps
// Datapath: lag table memory, indices, adder, reseed builder and range logic.
module alfrng_dp
    import alfrng_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INDEX_GAP   = DEF_INDEX_GAP,
    parameter int WORD_BITS   = DEF_WORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  ucw_t                         cw,
    input  logic [SEED_BITS-1:0]         seed,
    input  logic signed [RANGE_BITS-1:0] range_low,
    input  logic signed [RANGE_BITS-1:0] range_high,
    output dp_stat_t                     stat,
    output logic [VALUE_BITS-1:0]        result
);

    localparam int                IDX_W    = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0]  GAP_IDX  = IDX_W'(INDEX_GAP % TABLE_DEPTH);

    logic [WORD_BITS-1:0] lag_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [TABLE_DEPTH-1:0] vld_next;

    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;
    logic                 rd_a_vld_reg;
    logic                 rd_b_vld_reg;

    logic [IDX_W-1:0]     wi_reg;
    logic [IDX_W-1:0]     pi_reg;

    logic [WORD_BITS-1:0] fa_reg;
    logic [WORD_BITS-1:0] fb_reg;
    logic [FILL_BITS-1:0] fill_reg;

    logic signed [RANGE_BITS-1:0] lo_reg;
    logic [RANGE_BITS-1:0]        diff_reg;
    logic [RANGE_BITS-1:0]        mask_reg;
    logic                         small_reg;
    logic [TRY_BITS-1:0]          tries_reg;
    logic                         hit_reg;
    logic [RANGE_BITS-1:0]        num_reg;

    logic                 act_go_read;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;

    logic [WORD_BITS-1:0] op_a;
    logic [WORD_BITS-1:0] op_b;
    logic [WORD_BITS-1:0] sum;
    logic [63:0]          sum64;
    logic [63:0]          seed64;
    logic [WORD_BITS-1:0] seed_w;
    logic [7:0]           fill_ext;
    logic [IDX_W-1:0]     fill_addr;
    logic                 fill_in_range;
    logic [RANGE_BITS-1:0] num;
    logic                 hit;
    logic signed [RANGE_BITS:0] diff;
    logic signed [RANGE_BITS:0] rng_val;
    logic                 is_draw;

    assign op_a   = rd_a_vld_reg ? rd_a_reg : '0;
    assign op_b   = rd_b_vld_reg ? rd_b_reg : '0;
    assign sum    = op_a + op_b;
    assign sum64  = 64'(sum);
    assign seed64 = 64'(seed);
    assign seed_w = seed64[WORD_BITS-1:0];

    assign fill_ext      = {4'b0, fill_reg};
    assign fill_addr     = fill_ext[IDX_W-1:0];
    assign fill_in_range = ({24'b0, fill_ext} < 32'(TABLE_DEPTH));

    assign num = sum64[RANGE_BITS-1:0] & mask_reg;
    assign hit = (num <= diff_reg);

    assign diff = {range_high[RANGE_BITS-1], range_high}
                - {range_low[RANGE_BITS-1], range_low};

    assign is_draw     = (cw.act == ACT_DRAW) || (cw.act == ACT_DRAW_RNG);
    assign act_go_read = go && (cw.act == ACT_READ);

    assign stat.fill_more  = (fill_reg != FILL_LAST);
    assign stat.span_small = small_reg;
    assign stat.miss_more  = !hit && (tries_reg != TRY_LAST);

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = sum;
        if (go)
        begin
            unique case (cw.act)
                ACT_RS_INIT:
                begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = seed_w;
                end
                ACT_RS_FILL:
                begin
                    we    = fill_in_range;
                    waddr = fill_addr;
                    wdata = fb_reg;
                end
                ACT_DRAW, ACT_DRAW_RNG:
                begin
                    we    = 1'b1;
                    waddr = wi_reg;
                    wdata = sum;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // Reseed drops every entry, then the writes of entries up to nine make them valid again.
    always_comb
    begin
        vld_next = vld_reg;
        if (go && (cw.act == ACT_RS_INIT))
        begin
            vld_next = '0;
        end
        if (we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            lag_mem[waddr] <= wdata;
        end
        if (act_go_read)
        begin
            rd_a_reg <= lag_mem[wi_reg];
            rd_b_reg <= lag_mem[pi_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_go_read)
        begin
            rd_a_vld_reg <= vld_reg[wi_reg];
            rd_b_vld_reg <= vld_reg[pi_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            wi_reg    <= '0;
            pi_reg    <= '0;
            fill_reg  <= '0;
            tries_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (go)
            begin
                if (cw.act == ACT_RS_DONE)
                begin
                    wi_reg <= '0;
                    pi_reg <= GAP_IDX;
                end
                else if (is_draw)
                begin
                    wi_reg <= (wi_reg == LAST_IDX) ? '0 : wi_reg + IDX_W'(1);
                    pi_reg <= (pi_reg == LAST_IDX) ? '0 : pi_reg + IDX_W'(1);
                end

                if (cw.act == ACT_RS_INIT)
                begin
                    fill_reg <= FILL_BITS'(1);
                end
                else if (cw.act == ACT_RS_FILL)
                begin
                    fill_reg <= fill_reg + FILL_BITS'(1);
                end

                if (cw.act == ACT_LATCH)
                begin
                    tries_reg <= '0;
                    hit_reg   <= 1'b0;
                end
                else if (cw.act == ACT_DRAW_RNG)
                begin
                    tries_reg <= tries_reg + TRY_BITS'(1);
                    hit_reg   <= hit;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (cw.act == ACT_RS_INIT)
            begin
                fa_reg <= seed_w;
                fb_reg <= WORD_BITS'(1);
            end
            else if (cw.act == ACT_RS_FILL)
            begin
                fa_reg <= fb_reg;
                fb_reg <= fa_reg + fb_reg;
            end

            if (cw.act == ACT_LATCH)
            begin
                lo_reg    <= range_low;
                diff_reg  <= diff[RANGE_BITS-1:0];
                mask_reg  <= smear16(diff[RANGE_BITS-1:0]);
                small_reg <= diff[RANGE_BITS] || (diff == '0);
            end
            else if (cw.act == ACT_DRAW_RNG)
            begin
                num_reg <= num;
            end
        end
    end

    assign rng_val = {lo_reg[RANGE_BITS-1], lo_reg}
                   + {1'b0, (hit_reg ? num_reg : '0)};

    always_comb
    begin
        unique case (cw.sel)
            SEL_ZERO:   result = '0;
            SEL_SUM:    result = sum64[VALUE_BITS-1:0];
            SEL_RANGED: result = {{(VALUE_BITS-RANGE_BITS-1){rng_val[RANGE_BITS]}}, rng_val};
            default:    result = '0;
        endcase
    end

endmodule

// File: sv/additive_lagged_fibonacci_rng.sv
`timescale 1ns / 1ps
// Top level of the additive lagged Fibonacci generator.
//
//   Channel   Signals                              Direction
//   -------   ----------------------------------   ---------
//   input     in_valid, in_stall, op, range_*      beat in
//   output    out_valid, out_stall, value          beat out
//   config    psel, penable, pwrite, paddr, ...    APB write/read of seed_reg
//
// A raw draw steps through fetch, table read, and add with write back; the sum is then registered as the result.
// A ranged draw repeats table read and add for each try (at most 4096 tries); a span of one
// or less skips the tries.
// Reset invalidates the table, clears both indices and sets the seed to 1; no clearing pass is needed.
// A result waiting on out_stall holds only the step that would emit the next one.
module additive_lagged_fibonacci_rng
    import alfrng_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INDEX_GAP   = DEF_INDEX_GAP,
    parameter int WORD_BITS   = DEF_WORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_BITS-1:0]           op,
    input  logic signed [RANGE_BITS-1:0] range_low,
    input  logic signed [RANGE_BITS-1:0] range_high,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] value,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready
);

    logic [SEED_BITS-1:0]  seed_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] value_reg;

    ucw_t                  cw;
    logic                  go;
    dp_stat_t              stat;
    logic [VALUE_BITS-1:0] result;
    logic                  out_blocked;
    logic                  emit_fire;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SEED) ? DATA_BITS'(seed_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_SEED))
        begin
            seed_reg <= pwdata[SEED_BITS-1:0];
        end
    end

    assign out_blocked = out_valid_reg && out_stall;
    assign emit_fire   = go && cw.emit;

    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_blocked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            value_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    alfrng_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .op          (op),
        .out_blocked (out_blocked),
        .stat        (stat),
        .cw          (cw),
        .go          (go),
        .in_stall    (in_stall)
    );

    alfrng_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_GAP   (INDEX_GAP),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .cw         (cw),
        .seed       (seed_reg),
        .range_low  (range_low),
        .range_high (range_high),
        .stat       (stat),
        .result     (result)
    );

endmodule

// File: sv/alfrng_chk.sv
`timescale 1ns / 1ps
// Port-level checker of the lagged Fibonacci generator and its bind.
module alfrng_chk
    import alfrng_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [OP_BITS-1:0]           op,
    input logic signed [RANGE_BITS-1:0] range_low,
    input logic signed [RANGE_BITS-1:0] range_high,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [VALUE_BITS-1:0] value
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_value_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(value))
        else $error("output value changed while stalled");

    // Every operation leaves the sequencer busy in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("input taken on two cycles in a row");

    a_raw_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_RAW) && !out_valid |-> ##3 out_valid)
        else $error("raw draw result not delivered in three cycles");

    a_flat_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_RANGED) && (range_low == range_high) && !out_valid
        |-> ##3 (out_valid && (value[RANGE_BITS-1:0] == $past(range_low, 3))
                 && (value[VALUE_BITS-1:RANGE_BITS]
                     == {(VALUE_BITS-RANGE_BITS){$past(range_low[RANGE_BITS-1], 3)}})))
        else $error("ranged draw with equal bounds did not return the low bound");

endmodule

bind additive_lagged_fibonacci_rng alfrng_chk u_alfrng_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value)
);
